// ----- hw/rtl/tstm_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tstm_pkg: shared types and constants of the touch sample trimmed mean core
// Sizes of the sample store, the trim window and the fixed-point divide by
// three, and the control structs that pass between the modules.
// ----------------------------------------------------------------------------
package tstm_pkg;

  // Block sizes
  localparam int NUM_SAMPLES = 10;
  localparam int FIRST_KEPT  = 3;
  localparam int SAMPLE_BITS = 12;
  localparam int KEEP_COUNT  = 3;

  // Width of the output fields and of the raw input fields
  localparam int OUT_W = 12;
  localparam int RAW_W = 12;

  // Fill counter holds 0 .. NUM_SAMPLES-1
  localparam int CNT_W = $clog2(NUM_SAMPLES);

  // Sum of three samples, and divide by three as multiply and shift
  localparam int SUM_W    = SAMPLE_BITS + 2;
  localparam int DIV_SH   = SUM_W + 1;
  localparam int RECIP_W  = DIV_SH;
  localparam int PROD_W   = SUM_W + RECIP_W;
  localparam logic [RECIP_W-1:0] RECIP3 = RECIP_W'(((64'd1 << DIV_SH) + 64'd2) / 3);

  // Working width for the centre offset on X
  localparam int CALC_W = (SAMPLE_BITS > OUT_W) ? SAMPLE_BITS : OUT_W;
  localparam logic [CALC_W-1:0] MID_VALUE = CALC_W'((64'd1 << (SAMPLE_BITS - 1)) - 64'd1);

  typedef logic [SAMPLE_BITS-1:0] smp_t;
  typedef logic [CNT_W-1:0]       cnt_t;
  typedef logic [SUM_W-1:0]       sum_t;

  // Control from the burst sequencer to each sort lane
  typedef struct packed {
    logic ins;
    cnt_t fill;
  } lane_ctrl_t;

  // Control from the burst sequencer to the merge stage
  typedef struct packed {
    logic done;
  } merge_ctrl_t;

  // Status from the merge stage back to the sequencer
  typedef struct packed {
    logic sum_pend;
    logic out_pend;
  } merge_sts_t;

  // Sorted position of the k-th kept element, saturated at the last cell
  function automatic int clamp_idx(int k);
    return (k > NUM_SAMPLES - 1) ? NUM_SAMPLES - 1 : k;
  endfunction

endpackage

// ----- hw/rtl/tstm_in_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tstm_in_if: sample pair channel
// Valid/ready channel carrying one pen flag and one X/Y conversion pair.
// ----------------------------------------------------------------------------
interface tstm_in_if;
  logic                          valid;
  logic                          ready;
  logic                          pen_down;
  logic [tstm_pkg::RAW_W-1:0]    x_sample;
  logic [tstm_pkg::RAW_W-1:0]    y_sample;

  modport source (output valid, output pen_down, output x_sample, output y_sample,
                  input ready);
  modport sink   (input valid, input pen_down, input x_sample, input y_sample,
                  output ready);
endinterface

// ----- hw/rtl/tstm_out_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tstm_out_if: filtered position channel
// Valid/ready channel carrying one filtered X/Y position.
// ----------------------------------------------------------------------------
interface tstm_out_if;
  logic                              valid;
  logic                              ready;
  logic signed [tstm_pkg::OUT_W-1:0] pos_x;
  logic        [tstm_pkg::OUT_W-1:0] pos_y;

  modport source (output valid, output pos_x, output pos_y, input ready);
  modport sink   (input valid, input pos_x, input pos_y, output ready);
endinterface

// ----- hw/rtl/tstm_sort_lane.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tstm_sort_lane: insertion-sort cell chain for one axis
// Keeps the samples of the current burst in ascending order; each insert
// shifts the larger cells up by one and drops the new sample into the gap.
// ----------------------------------------------------------------------------
module tstm_sort_lane (
  input  logic                                               clk_i,
  input  tstm_pkg::lane_ctrl_t                               ctrl_i,
  input  tstm_pkg::smp_t                                     smp_i,
  output logic [tstm_pkg::KEEP_COUNT-1:0][tstm_pkg::SAMPLE_BITS-1:0] kept_o
);

  tstm_pkg::smp_t cell_q [tstm_pkg::NUM_SAMPLES];
  tstm_pkg::smp_t cell_d [tstm_pkg::NUM_SAMPLES];
  logic [tstm_pkg::NUM_SAMPLES-1:0] gt;

  // Flag occupied cells that hold a larger value than the new sample
  always_comb begin
    for (int i = 0; i < tstm_pkg::NUM_SAMPLES; i++) begin
      gt[i] = (tstm_pkg::CNT_W'(i) < ctrl_i.fill) && (cell_q[i] > smp_i);
    end
  end

  // Shift larger cells up, place the sample in the freed slot
  for (genvar i = 0; i < tstm_pkg::NUM_SAMPLES; i++) begin : g_cell
    logic take;
    assign take = gt[i] || (tstm_pkg::CNT_W'(i) == ctrl_i.fill);
    if (i == 0) begin : g_first
      assign cell_d[i] = take ? smp_i : cell_q[i];
    end else begin : g_rest
      assign cell_d[i] = take ? (gt[i-1] ? cell_q[i-1] : smp_i) : cell_q[i];
    end

    always_ff @(posedge clk_i) begin
      if (ctrl_i.ins) begin
        cell_q[i] <= cell_d[i];
      end
    end
  end

  // Tap the trim window
  for (genvar k = 0; k < tstm_pkg::KEEP_COUNT; k++) begin : g_kept
    assign kept_o[k] = cell_q[tstm_pkg::clamp_idx(tstm_pkg::FIRST_KEPT + k)];
  end

endmodule

// ----- hw/rtl/tstm_merge.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tstm_merge: trimmed mean of both lanes
// Sums the kept cells of each lane, divides by three through a reciprocal
// multiply, offsets X from the panel centre and holds the result.
// ----------------------------------------------------------------------------
module tstm_merge (
  input  logic                                                       clk_i,
  input  logic                                                       rst_ni,
  input  tstm_pkg::merge_ctrl_t                                      ctrl_i,
  input  logic [tstm_pkg::KEEP_COUNT-1:0][tstm_pkg::SAMPLE_BITS-1:0] kept_x_i,
  input  logic [tstm_pkg::KEEP_COUNT-1:0][tstm_pkg::SAMPLE_BITS-1:0] kept_y_i,
  output tstm_pkg::merge_sts_t                                       sts_o,
  tstm_out_if.source                                                 out_o
);

  logic                  sum_vld_q, sum_vld_d;
  logic                  out_vld_q, out_vld_d;
  tstm_pkg::sum_t        sum_x_q, sum_y_q;
  tstm_pkg::sum_t        sum_x_d, sum_y_d;
  logic                  adv;
  logic [tstm_pkg::PROD_W-1:0]  prod_x, prod_y;
  tstm_pkg::smp_t               mean_x, mean_y;
  logic [tstm_pkg::CALC_W-1:0]  diff_x, ext_y;
  logic signed [tstm_pkg::OUT_W-1:0] pos_x_q;
  logic [tstm_pkg::OUT_W-1:0]        pos_y_q;

  // Add the three kept cells of each lane
  assign sum_x_d = tstm_pkg::SUM_W'(kept_x_i[0]) + tstm_pkg::SUM_W'(kept_x_i[1])
                 + tstm_pkg::SUM_W'(kept_x_i[2]);
  assign sum_y_d = tstm_pkg::SUM_W'(kept_y_i[0]) + tstm_pkg::SUM_W'(kept_y_i[1])
                 + tstm_pkg::SUM_W'(kept_y_i[2]);

  // Divide by three and offset X from the centre
  assign prod_x = tstm_pkg::PROD_W'(sum_x_q) * tstm_pkg::PROD_W'(tstm_pkg::RECIP3);
  assign prod_y = tstm_pkg::PROD_W'(sum_y_q) * tstm_pkg::PROD_W'(tstm_pkg::RECIP3);
  assign mean_x = prod_x[tstm_pkg::DIV_SH +: tstm_pkg::SAMPLE_BITS];
  assign mean_y = prod_y[tstm_pkg::DIV_SH +: tstm_pkg::SAMPLE_BITS];
  assign diff_x = tstm_pkg::MID_VALUE - tstm_pkg::CALC_W'(mean_x);
  assign ext_y  = tstm_pkg::CALC_W'(mean_y);

  // Advance the sum into the output register when it is free
  always_comb begin
    adv       = sum_vld_q && (!out_vld_q || out_o.ready);
    sum_vld_d = ctrl_i.done || (sum_vld_q && !adv);
    if (adv) begin
      out_vld_d = 1'b1;
    end else if (out_o.ready) begin
      out_vld_d = 1'b0;
    end else begin
      out_vld_d = out_vld_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_vld_q <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      sum_vld_q <= sum_vld_d;
      out_vld_q <= out_vld_d;
    end
  end

  // Capture payloads
  always_ff @(posedge clk_i) begin
    if (ctrl_i.done) begin
      sum_x_q <= sum_x_d;
      sum_y_q <= sum_y_d;
    end
    if (adv) begin
      pos_x_q <= diff_x[tstm_pkg::OUT_W-1:0];
      pos_y_q <= ext_y[tstm_pkg::OUT_W-1:0];
    end
  end

  assign out_o.valid    = out_vld_q;
  assign out_o.pos_x    = pos_x_q;
  assign out_o.pos_y    = pos_y_q;
  assign sts_o.sum_pend = sum_vld_q;
  assign sts_o.out_pend = out_vld_q;

endmodule

// ----- hw/rtl/touch_sample_trimmed_mean_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// touch_sample_trimmed_mean_core: trimmed-mean filter for touch sample pairs
// Usage:
//   in_i carries one pen flag and one X/Y pair per transfer. A pair with the
//   pen up clears the burst. The first pair with the pen down is dropped, the
//   next ten are inserted into one sort chain per axis, one pair per cycle.
//   out_o carries the filtered position: X as centre minus the mean of sorted
//   elements 3..5, Y as the mean of sorted elements 3..5.
//   The tenth stored pair enters the chain, the done register marks the
//   burst, the sum register takes the window sum, and the output register
//   takes the divided, offset result. Throughput: one pair per cycle with
//   ready high; a burst is eleven pairs. The merge stage owns the kept cells
//   for the cycle after a burst ends, when only a dropped pair can arrive.
//   Stall: a result waits in the output register while new pairs are still
//   taken; ready drops only on the last pair of a burst while the previous
//   result is still in the merge stage or unread.
//   Reset clears the burst counter, the priming flag and both valid flags;
//   the sort cells are not cleared.
// ----------------------------------------------------------------------------
module touch_sample_trimmed_mean_core (
  input  logic       clk_i,
  input  logic       rst_ni,
  tstm_in_if.sink    in_i,
  tstm_out_if.source out_o
);

  tstm_pkg::cnt_t        fill_q, fill_d;
  logic                  primed_q, primed_d;
  logic                  done_q, done_d;
  logic                  acc, last, busy;
  tstm_pkg::lane_ctrl_t  lane_ctrl;
  tstm_pkg::merge_ctrl_t mrg_ctrl;
  tstm_pkg::merge_sts_t  mrg_sts;
  logic [tstm_pkg::CALC_W-1:0] x_ext, y_ext;
  tstm_pkg::smp_t        x_smp, y_smp;
  logic [tstm_pkg::KEEP_COUNT-1:0][tstm_pkg::SAMPLE_BITS-1:0] kept_x, kept_y;

  // Mask samples to the sample width
  assign x_ext = tstm_pkg::CALC_W'(in_i.x_sample);
  assign y_ext = tstm_pkg::CALC_W'(in_i.y_sample);
  assign x_smp = x_ext[tstm_pkg::SAMPLE_BITS-1:0];
  assign y_smp = y_ext[tstm_pkg::SAMPLE_BITS-1:0];

  // Hold the last pair of a burst while the merge stage is still occupied
  assign last       = primed_q && (fill_q == tstm_pkg::CNT_W'(tstm_pkg::NUM_SAMPLES - 1));
  assign busy       = done_q || mrg_sts.sum_pend || mrg_sts.out_pend;
  assign in_i.ready = !(last && busy);
  assign acc        = in_i.valid && in_i.ready;

  // Sequence the burst: drop, store, complete, abort
  always_comb begin
    fill_d         = fill_q;
    primed_d       = primed_q;
    done_d         = 1'b0;
    lane_ctrl.ins  = 1'b0;
    lane_ctrl.fill = fill_q;
    if (acc) begin
      if (!in_i.pen_down) begin
        fill_d   = '0;
        primed_d = 1'b0;
      end else if (!primed_q) begin
        fill_d   = '0;
        primed_d = 1'b1;
      end else begin
        lane_ctrl.ins = 1'b1;
        if (last) begin
          fill_d   = '0;
          primed_d = 1'b0;
          done_d   = 1'b1;
        end else begin
          fill_d = fill_q + tstm_pkg::CNT_W'(1);
        end
      end
    end
  end

  assign mrg_ctrl.done  = done_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q   <= '0;
      primed_q <= 1'b0;
      done_q   <= 1'b0;
    end else begin
      fill_q   <= fill_d;
      primed_q <= primed_d;
      done_q   <= done_d;
    end
  end

  // One sort lane per axis
  tstm_sort_lane u_lane_x (
    .clk_i  (clk_i),
    .ctrl_i (lane_ctrl),
    .smp_i  (x_smp),
    .kept_o (kept_x)
  );

  tstm_sort_lane u_lane_y (
    .clk_i  (clk_i),
    .ctrl_i (lane_ctrl),
    .smp_i  (y_smp),
    .kept_o (kept_y)
  );

  // Combine the lanes into one result
  tstm_merge u_merge (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctrl_i   (mrg_ctrl),
    .kept_x_i (kept_x),
    .kept_y_i (kept_y),
    .sts_o    (mrg_sts),
    .out_o    (out_o)
  );

  // A completed burst always finds the sum register free
  a_done_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> !mrg_sts.sum_pend)
    else $error("burst completed while a sum was pending");

  // A completed burst is captured into the sum register
  a_done_capt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |=> mrg_sts.sum_pend)
    else $error("completed burst not captured");

  // Completion restarts the burst
  a_done_rst: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> (fill_q == '0) && !primed_q)
    else $error("burst state not restarted after completion");

  // Fill count stays inside the store
  a_fill_rng: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= tstm_pkg::CNT_W'(tstm_pkg::NUM_SAMPLES - 1))
    else $error("fill count beyond store depth");

endmodule

// ----- bench/touch_sample_trimmed_mean_core_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// touch_sample_trimmed_mean_core_tb: self-checking bench for the touch filter
// Drives pen-down bursts, aborted bursts and pen-up noise into the sample
// channel with random gaps, stalls the position channel on its own pattern,
// and compares every position with a burst predictor kept in a scoreboard.
// ----------------------------------------------------------------------------

// Burst predictor and queue of expected positions
class tstm_position_board;
  typedef struct {
    logic signed [tstm_pkg::OUT_W-1:0] px;
    logic        [tstm_pkg::OUT_W-1:0] py;
  } position_t;

  tstm_pkg::smp_t x_held[tstm_pkg::NUM_SAMPLES];
  tstm_pkg::smp_t y_held[tstm_pkg::NUM_SAMPLES];
  int unsigned    stored;
  bit             settled;
  position_t      positions_q[$];
  int             errors;

  function new();
    stored  = 0;
    settled = 0;
    errors  = 0;
  endfunction

  // Sort one axis ascending and average the kept window, truncating
  function int unsigned window_mean(tstm_pkg::smp_t v[tstm_pkg::NUM_SAMPLES]);
    tstm_pkg::smp_t s[tstm_pkg::NUM_SAMPLES];
    tstm_pkg::smp_t key;
    int             j;
    int unsigned    pos;
    int unsigned    total;
    total = 0;
    for (int i = 0; i < tstm_pkg::NUM_SAMPLES; i++) begin
      key = v[i];
      j   = i;
      while (j > 0 && s[j-1] > key) begin
        s[j] = s[j-1];
        j--;
      end
      s[j] = key;
    end
    for (int k = 0; k < tstm_pkg::KEEP_COUNT; k++) begin
      pos = tstm_pkg::FIRST_KEPT + k;
      if (pos > tstm_pkg::NUM_SAMPLES - 1) pos = tstm_pkg::NUM_SAMPLES - 1;
      total += s[pos];
    end
    return total / tstm_pkg::KEEP_COUNT;
  endfunction

  // Advance the burst state for one accepted pair
  function void note_pair(logic pen, logic [tstm_pkg::RAW_W-1:0] xs,
                          logic [tstm_pkg::RAW_W-1:0] ys);
    int unsigned slot;
    int unsigned mx;
    int          centred;
    position_t   p;
    if (!pen) begin
      stored  = 0;
      settled = 0;
      return;
    end
    // Drop the settling pair at the head of each burst
    if (!settled) begin
      settled = 1;
      stored  = 0;
      return;
    end
    slot = (stored >= tstm_pkg::NUM_SAMPLES) ? tstm_pkg::NUM_SAMPLES - 1 : stored;
    x_held[slot] = tstm_pkg::smp_t'(xs);
    y_held[slot] = tstm_pkg::smp_t'(ys);
    if (slot + 1 < tstm_pkg::NUM_SAMPLES) begin
      stored = slot + 1;
      return;
    end
    mx      = window_mean(x_held);
    centred = ((1 << (tstm_pkg::SAMPLE_BITS - 1)) - 1) - int'(mx);
    p.px    = centred[tstm_pkg::OUT_W-1:0];
    p.py    = tstm_pkg::OUT_W'(window_mean(y_held));
    positions_q.push_back(p);
    stored  = 0;
    settled = 0;
  endfunction

  // Compare one position transfer with the oldest expectation
  function void check_position(logic signed [tstm_pkg::OUT_W-1:0] px,
                               logic [tstm_pkg::OUT_W-1:0] py);
    position_t p;
    if (positions_q.size() == 0) begin
      $display("%0t: unexpected position x=%0d y=%0d", $time, px, py);
      errors++;
      return;
    end
    p = positions_q.pop_front();
    if (px !== p.px) begin
      $display("%0t: pos_x expected %0d actual %0d", $time, p.px, px);
      errors++;
    end
    if (py !== p.py) begin
      $display("%0t: pos_y expected %0d actual %0d", $time, p.py, py);
      errors++;
    end
  endfunction

  function int outstanding();
    return positions_q.size();
  endfunction
endclass

module touch_sample_trimmed_mean_core_tb;

  localparam int RANDOM_PAIRS = 1000;
  localparam int CYCLE_LIMIT  = 200000;
  localparam logic [tstm_pkg::RAW_W-1:0] RAW_MAX = '1;

  typedef struct packed {
    logic                       pen;
    logic [tstm_pkg::RAW_W-1:0] xs;
    logic [tstm_pkg::RAW_W-1:0] ys;
  } pair_t;

  logic clk_i;
  logic rst_ni;
  int   cycles = 0;

  pair_t              pairs_q[$];
  tstm_position_board board;

  tstm_in_if  in_if ();
  tstm_out_if out_if ();

  touch_sample_trimmed_mean_core u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  initial clk_i = 1'b0;
  always #4 clk_i = ~clk_i;

  // Abort the run if it hangs
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // Watch both channels on the falling edge before the edge that completes a transfer
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (in_if.valid && in_if.ready)
        board.note_pair(in_if.pen_down, in_if.x_sample, in_if.y_sample);
      if (out_if.valid && out_if.ready)
        board.check_position(out_if.pos_x, out_if.pos_y);
    end
  end

  // Receiver: long ready stretches mixed with random stalls
  initial begin
    out_if.ready <= 1'b0;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      if ($urandom_range(0, 3) == 0) begin
        out_if.ready <= 1'b1;
        repeat ($urandom_range(20, 120)) @(posedge clk_i);
      end else begin
        out_if.ready <= 1'($urandom_range(0, 1));
        repeat ($urandom_range(1, 12)) @(posedge clk_i);
      end
    end
  end

  function automatic logic [tstm_pkg::RAW_W-1:0] pick_sample(
      int mode, logic [tstm_pkg::RAW_W-1:0] base);
    case (mode)
      0:       return tstm_pkg::RAW_W'($urandom);
      1:       return base + tstm_pkg::RAW_W'($urandom_range(0, 15));
      2:       return $urandom_range(0, 1) ? RAW_MAX : '0;
      default: return tstm_pkg::RAW_W'($urandom_range(0, 40));
    endcase
  endfunction

  // Queue a burst of pen-down pairs: the settling pair and then len more
  task automatic queue_burst(int len);
    int                         mode_x;
    int                         mode_y;
    logic [tstm_pkg::RAW_W-1:0] base_x;
    logic [tstm_pkg::RAW_W-1:0] base_y;
    mode_x = $urandom_range(0, 3);
    mode_y = $urandom_range(0, 3);
    base_x = tstm_pkg::RAW_W'($urandom);
    base_y = tstm_pkg::RAW_W'($urandom);
    for (int i = 0; i <= len; i++)
      pairs_q.push_back('{1'b1, pick_sample(mode_x, base_x), pick_sample(mode_y, base_y)});
  endtask

  task automatic queue_directed();
    pairs_q.push_back('{1'b0, RAW_MAX, '0});
    // Lowest mean on Y, highest on X: most negative X position
    for (int i = 0; i <= tstm_pkg::NUM_SAMPLES; i++)
      pairs_q.push_back('{1'b1, RAW_MAX, tstm_pkg::RAW_W'(0)});
    // Pen lifted part way through a burst
    pairs_q.push_back('{1'b1, 12'h5a5, 12'ha5a});
    pairs_q.push_back('{1'b1, 12'ha5a, 12'h5a5});
    pairs_q.push_back('{1'b0, '0, RAW_MAX});
    // Highest mean on Y, zero on X
    for (int i = 0; i <= tstm_pkg::NUM_SAMPLES; i++)
      pairs_q.push_back('{1'b1, tstm_pkg::RAW_W'(0), RAW_MAX});
  endtask

  task automatic queue_random();
    int count;
    int pick;
    count = 0;
    while (count < RANDOM_PAIRS) begin
      pick = $urandom_range(0, 9);
      if (pick == 0) begin
        // Pen-up noise
        repeat ($urandom_range(1, 3)) begin
          pairs_q.push_back('{1'b0, tstm_pkg::RAW_W'($urandom),
                              tstm_pkg::RAW_W'($urandom)});
          count++;
        end
      end else if (pick == 1) begin
        // Burst broken by a pen lift
        queue_burst($urandom_range(0, tstm_pkg::NUM_SAMPLES - 1));
        pairs_q.push_back('{1'b0, tstm_pkg::RAW_W'($urandom),
                            tstm_pkg::RAW_W'($urandom)});
        count += tstm_pkg::NUM_SAMPLES;
      end else begin
        queue_burst(tstm_pkg::NUM_SAMPLES);
        count += tstm_pkg::NUM_SAMPLES + 1;
      end
    end
  endtask

  // Sender: runs of back-to-back transfers separated by random gaps
  task automatic send_pairs();
    pair_t p;
    int    run_left;
    int    gap;
    run_left = 0;
    while (pairs_q.size() != 0) begin
      p   = pairs_q.pop_front();
      gap = 0;
      if (run_left == 0) begin
        run_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 80)
                                                : $urandom_range(1, 20);
        if ($urandom_range(0, 3) != 0) gap = $urandom_range(1, 8);
      end
      if (gap > 0) begin
        in_if.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      in_if.valid    <= 1'b1;
      in_if.pen_down <= p.pen;
      in_if.x_sample <= p.xs;
      in_if.y_sample <= p.ys;
      run_left--;
      // Hold until ready is seen with valid high, then let the transfer edge pass
      do @(negedge clk_i); while (!in_if.ready);
      @(posedge clk_i);
    end
    in_if.valid <= 1'b0;
  endtask

  initial begin
    board          = new();
    rst_ni         <= 1'b0;
    in_if.valid    <= 1'b0;
    in_if.pen_down <= 1'b0;
    in_if.x_sample <= '0;
    in_if.y_sample <= '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    queue_directed();
    queue_random();
    send_pairs();

    // Drain the remaining positions, then allow for the pipeline
    while (board.outstanding() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);

    if (board.errors == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

endmodule
